### src/stiff_string_fd_step_macros.svh
// Assertion macros shared by the string stepper RTL.
`ifndef STIFF_STRING_FD_STEP_MACROS_SVH
`define STIFF_STRING_FD_STEP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define FDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fdstr_pkg.sv
// Shared types, widths and helpers of the string stepper.
`default_nettype none

package fdstr_pkg;

  localparam int MAX_NODES = 256;
  localparam int FIRST_UPDATED_NODE = 2;
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W = ((NODE_W > 8) ? NODE_W : 8) + 1;
  localparam int BANK_W = 2;
  localparam int ADDR_W = BANK_W + NODE_W;
  localparam int MEM_DEPTH = 3 * MAX_NODES;
  localparam int VAL_W = 32;
  localparam int COEF_W = 32;
  localparam int D_W = 42;
  localparam int SUM_W = D_W + 2;
  localparam int MAG_W = D_W - 1;
  localparam int LO_W = 20;
  localparam int HI_W = MAG_W - LO_W;
  localparam int PROD_W = MAG_W + COEF_W;
  localparam int FRAC_W = 30;

  typedef logic signed [D_W-1:0] dval_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [VAL_W-1:0] val_t;

  localparam sum_t SAT_MAX = sum_t'(2147483647);
  localparam sum_t SAT_MIN = -SAT_MAX - sum_t'(1);

  typedef struct packed {
    logic              start;
    dval_t             d;
    logic [COEF_W-1:0] c;
  } mac_req_t;

  typedef struct packed {
    logic  done;
    dval_t r;
  } mac_rsp_t;

  function automatic val_t sat_val(input sum_t s);
    val_t r;
    if (s > SAT_MAX) begin
      r = val_t'(SAT_MAX);
    end else if (s < SAT_MIN) begin
      r = val_t'(SAT_MIN);
    end else begin
      r = val_t'(s);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/fdstr_mem.sv
// Displacement store: three node buffers in one RAM, one write and two read ports.
`default_nettype none

module fdstr_mem (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [fdstr_pkg::ADDR_W-1:0]  waddr_i,
  input  wire fdstr_pkg::val_t               wdata_i,
  input  wire logic                          rea_i,
  input  wire logic [fdstr_pkg::ADDR_W-1:0]  raddra_i,
  output fdstr_pkg::val_t                    rdataa_o,
  input  wire logic                          reb_i,
  input  wire logic [fdstr_pkg::ADDR_W-1:0]  raddrb_i,
  output fdstr_pkg::val_t                    rdatab_o
);

  fdstr_pkg::val_t mem_q [fdstr_pkg::MEM_DEPTH];
  fdstr_pkg::val_t rdataa_q;
  fdstr_pkg::val_t rdatab_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rea_i) begin
      rdataa_q <= mem_q[raddra_i];
    end
    if (reb_i) begin
      rdatab_q <= mem_q[raddrb_i];
    end
  end

  assign rdataa_o = rdataa_q;
  assign rdatab_o = rdatab_q;

endmodule

`default_nettype wire

### src/fdstr_mac.sv
// Shared coefficient multiplier: product scaled down by 2^30 with rounding.
`default_nettype none

module fdstr_mac (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fdstr_pkg::mac_req_t req_i,
  output fdstr_pkg::mac_rsp_t      rsp_o
);

  logic [3:0]                         v_q;
  logic                               neg1_q, neg2_q, neg3_q;
  logic [fdstr_pkg::MAG_W-1:0]        mag_q;
  logic [fdstr_pkg::COEF_W-1:0]       c1_q, c2_q;
  logic [fdstr_pkg::LO_W-1:0]         lo_q;
  logic [fdstr_pkg::HI_W+fdstr_pkg::COEF_W-1:0] hi_q;
  logic [fdstr_pkg::LO_W+fdstr_pkg::COEF_W-1:0] lo_prod;
  logic [fdstr_pkg::PROD_W-1:0]       full_q;
  logic [fdstr_pkg::PROD_W-1:0]       rnd_sum;
  logic [fdstr_pkg::D_W-1:0]          rnd;
  fdstr_pkg::dval_t                   neg_d;
  fdstr_pkg::dval_t                   r_q;

  assign neg_d   = -req_i.d;
  assign lo_prod = lo_q * c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], req_i.start};
    end
  end

  always_comb begin
    rnd_sum = full_q + (fdstr_pkg::PROD_W'(1) << (fdstr_pkg::FRAC_W - 1));
    rnd     = rnd_sum[fdstr_pkg::FRAC_W +: fdstr_pkg::D_W];
  end

  always_ff @(posedge clk_i) begin
    neg1_q <= req_i.d[fdstr_pkg::D_W-1];
    mag_q  <= req_i.d[fdstr_pkg::D_W-1] ? neg_d[fdstr_pkg::MAG_W-1:0]
                                        : req_i.d[fdstr_pkg::MAG_W-1:0];
    c1_q   <= req_i.c;
    neg2_q <= neg1_q;
    hi_q   <= mag_q[fdstr_pkg::MAG_W-1:fdstr_pkg::LO_W] * c1_q;
    lo_q   <= mag_q[fdstr_pkg::LO_W-1:0];
    c2_q   <= c1_q;
    neg3_q <= neg2_q;
    full_q <= {hi_q, {fdstr_pkg::LO_W{1'b0}}}
              + fdstr_pkg::PROD_W'(lo_prod);
    r_q    <= neg3_q ? -$signed(rnd) : $signed(rnd);
  end

  assign rsp_o.done = v_q[3];
  assign rsp_o.r    = r_q;

endmodule

`default_nettype wire

### src/stiff_string_fd_step.sv
// Top level of the stiff, damped string finite-difference stepper.
//
// Channel   Direction  Handshake                      Payload
// in        sink       in_valid_i / in_ready_o        action_i, node_index_i, node_value_i
// out       source     out_valid_o / out_ready_i      sample_o
// cfg       sink       cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// After reset a clearing pass writes zero to all 768 store entries, one per cycle.
// A write transfer writes the current buffer, then the previous one: both share one RAM write port.
// Per updated node in a tick the shared multiplier runs five products in turn, and each
// product is awaited before the next one is issued.
// The result waits in an output register; a stalled output holds the block before it is loaded.
`default_nettype none
`include "stiff_string_fd_step_macros.svh"

module stiff_string_fd_step (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  node_index_i,
  input  wire logic signed [31:0] node_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] sample_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WR_CUR, S_WR_PREV, S_FETCH, S_SHIFT, S_CALC,
    S_ISSUE, S_WAIT, S_WRITE, S_OUT_RD, S_OUT_DATA
  } state_e;

  typedef enum logic [2:0] {
    OP_WAVE, OP_NORM, OP_STIFF, OP_LOSS, OP_DIFF
  } op_e;

  typedef enum logic [2:0] {
    REG_NUM_NODES, REG_LAMBDA_SQ, REG_MU_SQ, REG_LOSS, REG_INV_NORM, REG_DIFF, REG_OUT_NODE
  } cfg_reg_e;

  localparam int CW = fdstr_pkg::CNT_W;
  localparam int NW = fdstr_pkg::NODE_W;

  state_e state_q;
  op_e    op_q;
  logic [fdstr_pkg::ADDR_W-1:0] clr_q;
  logic [1:0]  ph_q;
  logic [CW-1:0] l_q;
  logic [1:0]  f_q;
  logic        preload_q;
  logic        out_valid_q;
  fdstr_pkg::val_t sample_q;

  logic [7:0]  num_nodes_q, out_node_q;
  logic [31:0] lambda_q, mu_q, loss_q, inv_q, diff_q;

  logic [7:0]  idx_q;
  fdstr_pkg::val_t val_q;

  fdstr_pkg::val_t cw_q [5];
  fdstr_pkg::val_t pw_q [3];
  fdstr_pkg::dval_t lap1_q, dlap_q, bih_q, base_q, p0_q, core_q;
  fdstr_pkg::sum_t  sum_q;

  logic [1:0] cu_bank, pv_bank, nx_bank;
  logic [CW-1:0] n_eff, nn;
  logic idx_ok, out_ok;
  logic out_load;

  logic we, rea, reb;
  logic [fdstr_pkg::ADDR_W-1:0] waddr, raddra, raddrb;
  fdstr_pkg::val_t wdata, rdataa, rdatab;

  fdstr_pkg::mac_req_t mac_req;
  fdstr_pkg::mac_rsp_t mac_rsp;

  fdstr_pkg::dval_t c0, c1, c2, c3, c4, q0, q1, q2, lap1, lap2;

  assign nx_bank = ph_q;
  assign cu_bank = (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
  assign pv_bank = (ph_q == 2'd0) ? 2'd2 : ph_q - 2'd1;

  assign nn     = CW'(num_nodes_q);
  assign n_eff  = (nn > CW'(fdstr_pkg::MAX_NODES - 1)) ? CW'(fdstr_pkg::MAX_NODES - 1) : nn;
  assign idx_ok = CW'(idx_q) < CW'(fdstr_pkg::MAX_NODES);
  assign out_ok = CW'(out_node_q) < CW'(fdstr_pkg::MAX_NODES);

  assign out_load = (state_q == S_OUT_DATA) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  always_comb begin
    we     = 1'b0;
    waddr  = clr_q;
    wdata  = '0;
    rea    = 1'b0;
    reb    = 1'b0;
    raddra = '0;
    raddrb = '0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_WR_CUR: begin
        we    = idx_ok;
        waddr = {cu_bank, idx_q[NW-1:0]};
        wdata = val_q;
      end
      S_WR_PREV: begin
        we    = idx_ok;
        waddr = {pv_bank, idx_q[NW-1:0]};
        wdata = val_q;
      end
      S_FETCH: begin
        rea = 1'b1;
        reb = 1'b1;
        if (preload_q) begin
          raddra = {cu_bank, NW'(f_q)};
          raddrb = {pv_bank, NW'(f_q)};
        end else begin
          raddra = {cu_bank, NW'(l_q + CW'(2))};
          raddrb = {pv_bank, NW'(l_q + CW'(1))};
        end
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = {nx_bank, l_q[NW-1:0]};
        wdata = fdstr_pkg::sat_val(sum_q);
      end
      S_OUT_RD: begin
        rea    = 1'b1;
        raddra = {nx_bank, out_node_q[NW-1:0]};
      end
      default: begin
      end
    endcase
  end

  fdstr_mem u_mem (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .rea_i    (rea),
    .raddra_i (raddra),
    .rdataa_o (rdataa),
    .reb_i    (reb),
    .raddrb_i (raddrb),
    .rdatab_o (rdatab)
  );

  always_comb begin
    mac_req.start = (state_q == S_ISSUE);
    case (op_q)
      OP_WAVE:  begin mac_req.d = lap1_q; mac_req.c = lambda_q; end
      OP_NORM:  begin mac_req.d = core_q; mac_req.c = inv_q;    end
      OP_STIFF: begin mac_req.d = bih_q;  mac_req.c = mu_q;     end
      OP_LOSS:  begin mac_req.d = p0_q;   mac_req.c = loss_q;   end
      default:  begin mac_req.d = dlap_q; mac_req.c = diff_q;   end
    endcase
  end

  fdstr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      op_q        <= OP_WAVE;
      clr_q       <= '0;
      ph_q        <= '0;
      l_q         <= '0;
      f_q         <= '0;
      preload_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      num_nodes_q <= 8'd64;
      lambda_q    <= '0;
      mu_q        <= '0;
      loss_q      <= '0;
      inv_q       <= 32'd1073741824;
      diff_q      <= '0;
      out_node_q  <= 8'd32;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_NUM_NODES: num_nodes_q <= cfg_data_i[7:0];
          REG_LAMBDA_SQ: lambda_q    <= cfg_data_i;
          REG_MU_SQ:     mu_q        <= cfg_data_i;
          REG_LOSS:      loss_q      <= cfg_data_i;
          REG_INV_NORM:  inv_q       <= cfg_data_i;
          REG_DIFF:      diff_q      <= cfg_data_i;
          REG_OUT_NODE:  out_node_q  <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == fdstr_pkg::ADDR_W'(fdstr_pkg::MEM_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            if (!action_i) begin
              state_q <= S_WR_CUR;
            end else if (n_eff >= CW'(4)) begin
              l_q       <= CW'(fdstr_pkg::FIRST_UPDATED_NODE);
              f_q       <= '0;
              preload_q <= 1'b1;
              state_q   <= S_FETCH;
            end else begin
              state_q <= S_OUT_RD;
            end
          end
        end
        S_WR_CUR:  state_q <= S_WR_PREV;
        S_WR_PREV: state_q <= S_IDLE;
        S_FETCH:   state_q <= S_SHIFT;
        S_SHIFT: begin
          if (preload_q) begin
            if (f_q == 2'd3) begin
              preload_q <= 1'b0;
            end
            f_q     <= f_q + 2'd1;
            state_q <= S_FETCH;
          end else begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          op_q    <= OP_WAVE;
          state_q <= S_ISSUE;
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (mac_rsp.done) begin
            if (op_q == OP_DIFF) begin
              state_q <= S_WRITE;
            end else begin
              op_q    <= op_e'(op_q + 3'd1);
              state_q <= S_ISSUE;
            end
          end
        end
        S_WRITE: begin
          if (l_q + CW'(2) < n_eff) begin
            l_q     <= l_q + CW'(1);
            state_q <= S_FETCH;
          end else begin
            state_q <= S_OUT_RD;
          end
        end
        S_OUT_RD: state_q <= S_OUT_DATA;
        S_OUT_DATA: begin
          if (out_load) begin
            sample_q <= out_ok ? rdataa : '0;
            ph_q     <= pv_bank;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    c0   = fdstr_pkg::dval_t'(cw_q[0]);
    c1   = fdstr_pkg::dval_t'(cw_q[1]);
    c2   = fdstr_pkg::dval_t'(cw_q[2]);
    c3   = fdstr_pkg::dval_t'(cw_q[3]);
    c4   = fdstr_pkg::dval_t'(cw_q[4]);
    q0   = fdstr_pkg::dval_t'(pw_q[0]);
    q1   = fdstr_pkg::dval_t'(pw_q[1]);
    q2   = fdstr_pkg::dval_t'(pw_q[2]);
    lap1 = c1 - (c2 <<< 1) + c3;
    lap2 = q0 - (q1 <<< 1) + q2;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      idx_q <= node_index_i;
      val_q <= node_value_i;
    end
    if (state_q == S_SHIFT) begin
      cw_q[0] <= cw_q[1];
      cw_q[1] <= cw_q[2];
      cw_q[2] <= cw_q[3];
      cw_q[3] <= cw_q[4];
      cw_q[4] <= rdataa;
      if (!(preload_q && f_q == 2'd3)) begin
        pw_q[0] <= pw_q[1];
        pw_q[1] <= pw_q[2];
        pw_q[2] <= rdatab;
      end
    end
    if (state_q == S_CALC) begin
      lap1_q <= lap1;
      dlap_q <= lap1 - lap2;
      bih_q  <= c4 - (c3 <<< 2) + (c2 <<< 2) + (c2 <<< 1) - (c1 <<< 2) + c0;
      base_q <= (c2 <<< 1) - q1;
      p0_q   <= q1;
      sum_q  <= '0;
    end
    if (state_q == S_WAIT && mac_rsp.done) begin
      case (op_q)
        OP_WAVE:  core_q <= base_q + mac_rsp.r;
        OP_STIFF: sum_q  <= sum_q - fdstr_pkg::sum_t'(mac_rsp.r);
        default:  sum_q  <= sum_q + fdstr_pkg::sum_t'(mac_rsp.r);
      endcase
    end
  end

  `FDS_ASSERT_NOW(a_phase_legal, 1'b1, ph_q != 2'd3, "rotation phase out of range")
  `FDS_ASSERT_NOW(a_no_bank3_write, we, waddr[fdstr_pkg::ADDR_W-1 -: 2] != 2'd3,
                  "write to nonexistent buffer")
  `FDS_ASSERT_NOW(a_mac_done_waited, mac_rsp.done, state_q == S_WAIT,
                  "multiplier result arrived outside wait state")
  `FDS_ASSERT_NEXT(a_out_load_rotates, state_q == S_OUT_DATA && (!out_valid_q || out_ready_i),
                   out_valid_q && state_q == S_IDLE, "tick result not loaded")

endmodule

`default_nettype wire
